// ===== sv/ctw_pkg.sv =====
// Shared types and constants of the character-cell console writer.
package ctw_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 64;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int CHAR_W     = 8;
  localparam int RGB_W      = 24;
  localparam int CELL_W     = CHAR_W + 2 * RGB_W;
  localparam int OP_W       = 3;
  localparam int CFG_COLS_W = 8;
  localparam int CFG_ROWS_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS         = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FORE = CFG_IDX_W'(2);

  localparam logic [CFG_COLS_W-1:0] COLUMNS_RESET = CFG_COLS_W'(80);
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET    = CFG_ROWS_W'(25);

  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] PRINT_LO     = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HI     = 8'd126;
  localparam logic [RGB_W-1:0]  RGB_WHITE    = 24'hFFFFFF;
  localparam logic [RGB_W-1:0]  RGB_BLACK    = 24'h000000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_PUT   = 3'd1,
    OP_SET   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_BACK  = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [ROW_W-1:0] row0;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
  } walk_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } walk_st_t;

  typedef struct packed {
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [RGB_W-1:0] default_fore;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [CHAR_W-1:0] cell_char;
    logic [RGB_W-1:0]  cell_fore;
    logic [RGB_W-1:0]  cell_back;
    logic              scrolled;
  } result_t;

endpackage

// ===== sv/text_console_cell_writer_unit.sv =====
// Character-cell text console: configuration registers, sequencer and result register.
//
// A grid of up to 128 x 64 cells (character, RGB foreground, RGB background) with a
// cursor, held in one cell memory with a single write and a single read port. After
// reset the block fills the whole memory, one cell per cycle, with in_stall_o high;
// configuration writes are taken meanwhile. Write char, put at, set cursor, backspace
// and read cell pass through the execute and done states. A clear sweeps every cell. A
// write that scrolls copies each row in use up one row through the memory read port
// and then blanks the bottom row. The memory port and its address walker pace all of
// these sweeps. One word is worked on at a time; a result waits in the output register
// until taken.
module text_console_cell_writer_unit
  import ctw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [COL_W-1:0]      column_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [RGB_W-1:0]      fore_color_i,
  input  logic [RGB_W-1:0]      back_color_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COL_W-1:0]      cursor_column_o,
  output logic [ROW_W-1:0]      cursor_row_o,
  output logic [CHAR_W-1:0]     cell_char_o,
  output logic [RGB_W-1:0]      cell_fore_o,
  output logic [RGB_W-1:0]      cell_back_o,
  output logic                  scrolled_o
);

  logic [CFG_COLS_W-1:0] columns_q;
  logic [CFG_ROWS_W-1:0] rows_q;
  logic [RGB_W-1:0]      dfore_q;

  cfg_t    cfg;
  result_t res;
  logic    out_free;
  logic    out_valid_q, out_valid_d;

  logic [COL_W-1:0]  ocol_q;
  logic [ROW_W-1:0]  orow_q;
  logic [CHAR_W-1:0] ochar_q;
  logic [RGB_W-1:0]  ofore_q;
  logic [RGB_W-1:0]  oback_q;
  logic              oscr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      rows_q    <= ROWS_RESET;
      dfore_q   <= RGB_WHITE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COLUMNS:      columns_q <= cfg_data_i[CFG_COLS_W-1:0];
        CFG_ROWS:         rows_q    <= cfg_data_i[CFG_ROWS_W-1:0];
        CFG_DEFAULT_FORE: dfore_q   <= cfg_data_i[RGB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero acts as one, oversize clamps to the store
  always_comb begin
    if (columns_q == '0) begin
      cfg.last_col = '0;
    end else if (columns_q > CFG_COLS_W'(MAX_COLS)) begin
      cfg.last_col = COL_W'(MAX_COLS - 1);
    end else begin
      cfg.last_col = COL_W'(columns_q - CFG_COLS_W'(1));
    end
    if (rows_q == '0) begin
      cfg.last_row = '0;
    end else if (rows_q > CFG_ROWS_W'(MAX_ROWS)) begin
      cfg.last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      cfg.last_row = ROW_W'(rows_q - CFG_ROWS_W'(1));
    end
    cfg.default_fore = dfore_q;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  ctw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .char_code_i (char_code_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .fore_color_i(fore_color_i),
    .back_color_i(back_color_i),
    .cfg_i       (cfg),
    .out_free_i  (out_free),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      ocol_q  <= res.cur_col;
      orow_q  <= res.cur_row;
      ochar_q <= res.cell_char;
      ofore_q <= res.cell_fore;
      oback_q <= res.cell_back;
      oscr_q  <= res.scrolled;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_column_o = ocol_q;
  assign cursor_row_o    = orow_q;
  assign cell_char_o     = ochar_q;
  assign cell_fore_o     = ofore_q;
  assign cell_back_o     = oback_q;
  assign scrolled_o      = oscr_q;

`ifndef ASSERT_OFF
  a_scroll_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scrolled_o) |-> (cursor_column_o == '0))
    else $error("scrolled word with cursor off column zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again straight after an accept");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared without a busy sequencer");
`endif

endmodule

// ===== sv/ctw_cell_ram.sv =====
// Simple dual-port cell memory with registered read data.
module ctw_cell_ram #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 56
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ctw_walker.sv =====
// Row/column address walker shared by reset fill, clear, scroll copy and row blanking.
module ctw_walker
  import ctw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  walk_ctl_t ctl_i,
  output walk_st_t  st_o
);

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] lc_q, lc_d;
  logic [ROW_W-1:0] lr_q, lr_d;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    lc_d  = lc_q;
    lr_d  = lr_q;
    if (ctl_i.load) begin
      row_d = ctl_i.row0;
      col_d = '0;
      lc_d  = ctl_i.last_col;
      lr_d  = ctl_i.last_row;
    end else if (ctl_i.step) begin
      if (col_q == lc_q) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // reset setting sweeps the whole store for the power-up fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      lc_q  <= '1;
      lr_q  <= '1;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      lc_q  <= lc_d;
      lr_q  <= lr_d;
    end
  end

  assign st_o.row  = row_q;
  assign st_o.col  = col_q;
  assign st_o.last = (col_q == lc_q) && (row_q == lr_q);

endmodule

// ===== sv/ctw_ctrl.sv =====
// Operation sequencer: cursor, cell memory and the sweeps that drive it.
module ctw_ctrl
  import ctw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [RGB_W-1:0]  fore_color_i,
  input  logic [RGB_W-1:0]  back_color_i,
  input  cfg_t              cfg_i,
  input  logic              out_free_i,
  output result_t           res_o
);

  state_e state_q, state_d;

  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [RGB_W-1:0]  fg_q;
  logic [RGB_W-1:0]  bg_q;

  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [RGB_W-1:0]  fill_q, fill_d;
  logic              scr_q, scr_d;
  logic              rdok_q, rdok_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  walk_ctl_t walk;
  walk_st_t  wst;

  logic              accept;
  logic [COL_W-1:0]  col_s;
  logic [ROW_W-1:0]  row_s;
  logic              in_grid;
  logic              printable;
  logic              nl;

  ctw_cell_ram #(
    .ADDR_W(ADDR_W),
    .DATA_W(CELL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  ctw_walker u_walker (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (walk),
    .st_o  (wst)
  );

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign col_s     = (cur_col_q > cfg_i.last_col) ? cfg_i.last_col : cur_col_q;
  assign row_s     = (cur_row_q > cfg_i.last_row) ? cfg_i.last_row : cur_row_q;
  assign in_grid   = (col_q <= cfg_i.last_col) && (row_q <= cfg_i.last_row);
  assign printable = (ch_q >= PRINT_LO) && (ch_q <= PRINT_HI);
  assign nl        = (ch_q == NEWLINE_CODE) || (printable && (col_s == cfg_i.last_col));

  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    fill_d      = fill_q;
    scr_d       = scr_q;
    rdok_d      = rdok_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    walk        = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_INIT: begin
        we        = 1'b1;
        waddr     = {wst.row, wst.col};
        wdata     = {BLANK_CODE, RGB_WHITE, RGB_BLACK};
        walk.step = 1'b1;
        if (wst.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          scr_d   = 1'b0;
          rdok_d  = 1'b0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (op_q)
          OP_WRITE: begin
            cur_col_d = col_s;
            cur_row_d = row_s;
            if (printable) begin
              we        = 1'b1;
              waddr     = {row_s, col_s};
              wdata     = {ch_q, fg_q, bg_q};
              cur_col_d = col_s + COL_W'(1);
            end
            if (nl) begin
              cur_col_d = '0;
              if (row_s == cfg_i.last_row) begin
                scr_d         = 1'b1;
                walk.load     = 1'b1;
                walk.last_col = cfg_i.last_col;
                walk.last_row = cfg_i.last_row;
                if (cfg_i.last_row == '0) begin
                  walk.row0 = cfg_i.last_row;
                  state_d   = ST_BLANK;
                end else begin
                  walk.row0 = ROW_W'(1);
                  state_d   = ST_SCROLL;
                end
              end else begin
                cur_row_d = row_s + ROW_W'(1);
              end
            end
          end
          OP_PUT: begin
            if (in_grid) begin
              we    = 1'b1;
              waddr = {row_q, col_q};
              wdata = {ch_q, fg_q, bg_q};
            end
          end
          OP_SET: begin
            if (in_grid) begin
              cur_col_d = col_q;
              cur_row_d = row_q;
            end
          end
          OP_CLEAR: begin
            fill_d        = bg_q;
            cur_col_d     = '0;
            cur_row_d     = '0;
            walk.load     = 1'b1;
            walk.row0     = '0;
            walk.last_col = '1;
            walk.last_row = '1;
            state_d       = ST_CLEAR;
          end
          OP_BACK: begin
            cur_col_d = col_s;
            cur_row_d = row_s;
            if (col_s != '0) begin
              cur_col_d = col_s - COL_W'(1);
              we        = 1'b1;
              waddr     = {row_s, col_s - COL_W'(1)};
              wdata     = {BLANK_CODE, cfg_i.default_fore, fill_q};
            end
          end
          OP_READ: begin
            if (in_grid) begin
              re     = 1'b1;
              raddr  = {row_q, col_q};
              rdok_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCROLL: begin
        // read one row down, write it one row up in the following cycle
        re          = 1'b1;
        raddr       = {wst.row, wst.col};
        pend_d      = 1'b1;
        pend_addr_d = {wst.row - ROW_W'(1), wst.col};
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_addr_q;
          wdata = rdata;
        end
        walk.step = 1'b1;
        if (wst.last) begin
          walk.load     = 1'b1;
          walk.row0     = cfg_i.last_row;
          walk.last_col = cfg_i.last_col;
          walk.last_row = cfg_i.last_row;
          state_d       = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_addr_q;
          wdata = rdata;
        end else begin
          we        = 1'b1;
          waddr     = {wst.row, wst.col};
          wdata     = {BLANK_CODE, cfg_i.default_fore, fill_q};
          walk.step = 1'b1;
          if (wst.last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        we        = 1'b1;
        waddr     = {wst.row, wst.col};
        wdata     = {BLANK_CODE, cfg_i.default_fore, fill_q};
        walk.step = 1'b1;
        if (wst.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.valid     = (state_q == ST_DONE);
  assign res_o.cur_col   = cur_col_q;
  assign res_o.cur_row   = cur_row_q;
  assign res_o.cell_char = rdok_q ? rdata[CELL_W-1 -: CHAR_W] : '0;
  assign res_o.cell_fore = rdok_q ? rdata[2*RGB_W-1 -: RGB_W] : '0;
  assign res_o.cell_back = rdok_q ? rdata[RGB_W-1:0] : '0;
  assign res_o.scrolled  = scr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      fill_q      <= RGB_BLACK;
      scr_q       <= 1'b0;
      rdok_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      fill_q      <= fill_d;
      scr_q       <= scr_d;
      rdok_q      <= rdok_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      ch_q  <= char_code_i;
      col_q <= column_i;
      row_q <= row_i;
      fg_q  <= fore_color_i;
      bg_q  <= back_color_i;
    end
  end

endmodule

// ===== tb/text_console_cell_writer_unit_tb.sv =====
// Self-checking testbench of the character-cell console writer, with its own screen predictor.
module text_console_cell_writer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctw_pkg::*;

  localparam int CELLS        = MAX_COLS * MAX_ROWS;
  localparam int STALL_LIMIT  = 100000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [RGB_W-1:0]  fg;
    logic [RGB_W-1:0]  bg;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  caret_x;
    logic [ROW_W-1:0]  caret_y;
    logic [CHAR_W-1:0] ch;
    logic [RGB_W-1:0]  fg;
    logic [RGB_W-1:0]  bg;
    logic              scrolled;
  } console_resp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       operation_i = '0;
  logic [CHAR_W-1:0]     char_code_i = '0;
  logic [COL_W-1:0]      column_i = '0;
  logic [ROW_W-1:0]      row_i = '0;
  logic [RGB_W-1:0]      fore_color_i = '0;
  logic [RGB_W-1:0]      back_color_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COL_W-1:0]      cursor_column_o;
  logic [ROW_W-1:0]      cursor_row_o;
  logic [CHAR_W-1:0]     cell_char_o;
  logic [RGB_W-1:0]      cell_fore_o;
  logic [RGB_W-1:0]      cell_back_o;
  logic                  scrolled_o;

  text_console_cell_writer_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .char_code_i     (char_code_i),
    .column_i        (column_i),
    .row_i           (row_i),
    .fore_color_i    (fore_color_i),
    .back_color_i    (back_color_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o),
    .cell_char_o     (cell_char_o),
    .cell_fore_o     (cell_fore_o),
    .cell_back_o     (cell_back_o),
    .scrolled_o      (scrolled_o)
  );

  // predicted screen state
  logic [CHAR_W-1:0]     grid_char [CELLS];
  logic [RGB_W-1:0]      grid_fore [CELLS];
  logic [RGB_W-1:0]      grid_back [CELLS];
  int unsigned           caret_col;
  int unsigned           caret_row;
  logic [RGB_W-1:0]      blank_back;
  logic [CFG_COLS_W-1:0] width_reg;
  logic [CFG_ROWS_W-1:0] height_reg;
  logic [RGB_W-1:0]      ink_reg;

  console_cmd_t  pending_words[$];
  console_resp_t expected_cells[$];
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   gap_left;
  int unsigned   hold_left;
  int unsigned   quiet_cycles;
  bit            steady;
  console_cmd_t  next_word;
  console_cmd_t  taken_word;

  function automatic int unsigned cols_in_use();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return width_reg;
  endfunction

  function automatic int unsigned rows_in_use();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return height_reg;
  endfunction

  function automatic void store_cell(input int unsigned x, input int unsigned y,
                                     input logic [CHAR_W-1:0] ch,
                                     input logic [RGB_W-1:0] fg, input logic [RGB_W-1:0] bg);
    int unsigned idx;
    idx = y * MAX_COLS + x;
    if (x >= MAX_COLS || y >= MAX_ROWS) return;
    grid_char[idx] = ch;
    grid_fore[idx] = fg;
    grid_back[idx] = bg;
  endfunction

  function automatic void scroll_grid();
    int unsigned nc, nr, rr, cc, dst, src;
    nc = cols_in_use();
    nr = rows_in_use();
    for (rr = 1; rr < nr; rr++) begin
      for (cc = 0; cc < nc; cc++) begin
        dst = (rr - 1) * MAX_COLS + cc;
        src = rr * MAX_COLS + cc;
        grid_char[dst] = grid_char[src];
        grid_fore[dst] = grid_fore[src];
        grid_back[dst] = grid_back[src];
      end
    end
    for (cc = 0; cc < nc; cc++) store_cell(cc, nr - 1, BLANK_CODE, ink_reg, blank_back);
  endfunction

  function automatic bit line_feed();
    caret_col = 0;
    caret_row++;
    if (caret_row >= rows_in_use()) begin
      scroll_grid();
      caret_row = rows_in_use() - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clamp_caret();
    if (caret_col >= cols_in_use()) caret_col = cols_in_use() - 1;
    if (caret_row >= rows_in_use()) caret_row = rows_in_use() - 1;
  endfunction

  function automatic console_resp_t console_step(input console_cmd_t w);
    console_resp_t r;
    int unsigned   x, y, i;
    bit            hit;
    r   = '0;
    x   = w.x;
    y   = w.y;
    hit = (x < cols_in_use()) && (y < rows_in_use());
    case (w.op)
      OP_WRITE: begin
        clamp_caret();
        if (w.code == NEWLINE_CODE) begin
          r.scrolled = line_feed();
        end else if (w.code >= PRINT_LO && w.code <= PRINT_HI) begin
          store_cell(caret_col, caret_row, w.code, w.fg, w.bg);
          caret_col++;
          if (caret_col >= cols_in_use()) r.scrolled = line_feed();
        end
      end
      OP_PUT: begin
        if (hit) store_cell(x, y, w.code, w.fg, w.bg);
      end
      OP_SET: begin
        if (hit) begin
          caret_col = x;
          caret_row = y;
        end
      end
      OP_CLEAR: begin
        blank_back = w.bg;
        for (i = 0; i < CELLS; i++) begin
          grid_char[i] = BLANK_CODE;
          grid_fore[i] = ink_reg;
          grid_back[i] = w.bg;
        end
        caret_col = 0;
        caret_row = 0;
      end
      OP_BACK: begin
        clamp_caret();
        if (caret_col > 0) begin
          caret_col--;
          store_cell(caret_col, caret_row, BLANK_CODE, ink_reg, blank_back);
        end
      end
      OP_READ: begin
        if (hit) begin
          i    = y * MAX_COLS + x;
          r.ch = grid_char[i];
          r.fg = grid_fore[i];
          r.bg = grid_back[i];
        end
      end
      default: ;
    endcase
    r.caret_x = COL_W'(caret_col);
    r.caret_y = ROW_W'(caret_row);
    return r;
  endfunction

  function automatic console_cmd_t make_word(input logic [OP_W-1:0] op,
                                             input logic [CHAR_W-1:0] code,
                                             input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y,
                                             input logic [RGB_W-1:0] fg,
                                             input logic [RGB_W-1:0] bg);
    console_cmd_t w;
    w = {op, code, x, y, fg, bg};
    return w;
  endfunction

  function automatic logic [RGB_W-1:0] random_rgb();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return RGB_BLACK;
    if (pick == 1) return RGB_WHITE;
    return RGB_W'($urandom);
  endfunction

  function automatic console_cmd_t random_word(input int unsigned write_pct,
                                               input bit with_clear);
    console_cmd_t w;
    int unsigned  pick;
    w.fg   = random_rgb();
    w.bg   = random_rgb();
    w.code = CHAR_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 8) begin
      w.x = COL_W'($urandom_range(0, cols_in_use() - 1));
      w.y = ROW_W'($urandom_range(0, rows_in_use() - 1));
    end else begin
      w.x = COL_W'($urandom_range(0, MAX_COLS - 1));
      w.y = ROW_W'($urandom_range(0, MAX_ROWS - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < write_pct) begin
      w.op = OP_WRITE;
      pick = $urandom_range(0, 99);
      if (pick < 12) w.code = NEWLINE_CODE;
      else if (pick < 92) w.code = CHAR_W'($urandom_range(PRINT_LO, PRINT_HI));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 22) w.op = OP_PUT;
      else if (pick < 40) w.op = OP_SET;
      else if (pick < 58) w.op = OP_BACK;
      else if (pick < 93) w.op = OP_READ;
      else if (pick < 97) w.op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
      else w.op = with_clear ? OP_CLEAR : OP_READ;
    end
    return w;
  endfunction

  // random words, a quarter of the time a run of text closed by a newline
  task automatic fill_phase(input int unsigned count, input int unsigned write_pct,
                            input bit with_clear, input bit calm);
    console_cmd_t w;
    int unsigned  made, len, span;
    @(negedge clk_i);
    steady = calm;
    made   = 0;
    while (made < count) begin
      if ($urandom_range(0, 3) == 0) begin
        span = (cols_in_use() < 20) ? cols_in_use() + 1 : 20;
        len  = $urandom_range(1, span);
        repeat (len) pending_words.push_back(random_word(100, with_clear));
        w      = random_word(100, with_clear);
        w.code = NEWLINE_CODE;
        pending_words.push_back(w);
        made += len + 1;
      end else begin
        pending_words.push_back(random_word(write_pct, with_clear));
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_cells.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_COLUMNS:      width_reg  = CFG_COLS_W'(val);
      CFG_ROWS:         height_reg = CFG_ROWS_W'(val);
      CFG_DEFAULT_FORE: ink_reg    = RGB_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_grid(input int unsigned cols, input int unsigned rows,
                          input int unsigned fore);
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_DEFAULT_FORE, fore);
  endtask

  function automatic void compare_field(input string name, input logic [RGB_W-1:0] want,
                                        input logic [RGB_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    console_resp_t want;
    if (expected_cells.size() == 0) begin
      mismatches++;
      $display("%0t: result word with nothing expected, cursor %0d,%0d", $time,
               cursor_column_o, cursor_row_o);
      return;
    end
    want = expected_cells.pop_front();
    compare_field("cursor_column", want.caret_x, cursor_column_o);
    compare_field("cursor_row", want.caret_y, cursor_row_o);
    compare_field("cell_char", want.ch, cell_char_o);
    compare_field("cell_fore", want.fg, cell_fore_o);
    compare_field("cell_back", want.bg, cell_back_o);
    compare_field("scrolled", want.scrolled, scrolled_o);
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        taken_word = {operation_i, char_code_i, column_i, row_i, fore_color_i, back_color_i};
        expected_cells.push_back(console_step(taken_word));
        gap_left = steady ? 0 : $urandom_range(0, 15);
      end
      if (in_valid_i && in_stall_o) begin
        // hold the word
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        {operation_i, char_code_i, column_i, row_i, fore_color_i, back_color_i} <= next_word;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side; now and then a long hold-off so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_result();
        results_seen++;
        if (results_seen % 400 == 150) hold_left = LONG_HOLD;
        else hold_left = steady ? 0 : $urandom_range(0, 15);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned i, ph;
    mismatches   = 0;
    results_seen = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    for (i = 0; i < CELLS; i++) begin
      grid_char[i] = BLANK_CODE;
      grid_fore[i] = RGB_WHITE;
      grid_back[i] = RGB_BLACK;
    end
    caret_col  = 0;
    caret_row  = 0;
    blank_back = RGB_BLACK;
    width_reg  = COLUMNS_RESET;
    height_reg = ROWS_RESET;
    ink_reg    = RGB_WHITE;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words on the reset grid of 80 x 25
    @(negedge clk_i);
    pending_words.push_back(make_word(OP_READ, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_READ, 0, 127, 63, 0, 0));
    pending_words.push_back(make_word(OP_WRITE, 8'h41, 0, 0, RGB_WHITE, RGB_BLACK));
    pending_words.push_back(make_word(OP_WRITE, PRINT_LO, 0, 0, RGB_BLACK, RGB_WHITE));
    pending_words.push_back(make_word(OP_WRITE, PRINT_HI, 0, 0, 24'h123456, 24'h654321));
    pending_words.push_back(make_word(OP_WRITE, 8'd127, 0, 0, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_WRITE, 8'd31, 0, 0, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_WRITE, 8'd0, 0, 0, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_WRITE, 8'd255, 0, 0, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_WRITE, NEWLINE_CODE, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_PUT, 8'd255, 79, 24, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_PUT, 8'h42, 80, 0, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_PUT, 8'h43, 0, 25, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_READ, 0, 79, 24, 0, 0));
    pending_words.push_back(make_word(OP_READ, 0, 2, 0, 0, 0));
    pending_words.push_back(make_word(OP_SET, 0, 80, 24, 0, 0));
    pending_words.push_back(make_word(OP_SET, 0, 79, 24, 0, 0));
    pending_words.push_back(make_word(OP_WRITE, 8'h5A, 0, 0, 24'hA5A5A5, 24'h5A5A5A));
    pending_words.push_back(make_word(OP_READ, 0, 79, 23, 0, 0));
    pending_words.push_back(make_word(OP_BACK, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_WRITE, 8'h71, 0, 0, 24'h00FF00, 24'h0000FF));
    pending_words.push_back(make_word(OP_BACK, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_READ, 0, 0, 24, 0, 0));
    pending_words.push_back(make_word(OP_SPARE_6, 8'h41, 1, 1, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_SPARE_7, 8'h41, 1, 1, RGB_WHITE, RGB_WHITE));
    pending_words.push_back(make_word(OP_CLEAR, 0, 0, 0, 0, 24'h123456));
    pending_words.push_back(make_word(OP_READ, 0, 79, 24, 0, 0));
    wait_idle();

    // sizes of zero act as one
    set_grid(0, 0, 0);
    fill_phase(60, 50, 1'b1, 1'b0);
    wait_idle();

    // oversized registers saturate to the full store; park the cursor in the far corner
    set_grid(255, 127, 24'hFFFFFF);
    fill_phase(40, 30, 1'b0, 1'b0);
    pending_words.push_back(make_word(OP_SET, 0, 127, 63, 0, 0));
    wait_idle();

    // shrink under the cursor
    set_grid(6, 3, random_rgb());
    @(negedge clk_i);
    pending_words.push_back(make_word(OP_READ, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_WRITE, 8'h78, 0, 0, RGB_WHITE, RGB_BLACK));
    fill_phase(100, 45, 1'b1, 1'b0);
    wait_idle();

    set_grid(COLUMNS_RESET, ROWS_RESET, random_rgb());
    fill_phase(100, 50, 1'b1, 1'b1);
    wait_idle();

    set_grid(MAX_COLS, MAX_ROWS, random_rgb());
    fill_phase(30, 30, 1'b0, 1'b0);
    wait_idle();

    for (ph = 0; ph < 12; ph++) begin
      set_grid($urandom_range(0, 24), $urandom_range(0, 12), random_rgb());
      fill_phase(100, 45, 1'b1, ph % 4 == 1);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
